/* rtl/dtc_pkg.sv */
// Package for the token classifier: character classes, automaton states, token kinds,
// keyword patterns and the transition function of the lexing automaton.
// Depends on nothing; used by dfa_token_classifier_unit.
package dtc_pkg;

  // Character classes seen by the automaton.
  typedef enum logic [2:0] {
    CL_LETTER = 3'd0,
    CL_DIGIT  = 3'd1,
    CL_GT     = 3'd2,
    CL_LT     = 3'd3,
    CL_EQ     = 3'd4,
    CL_ARITH  = 3'd5,
    CL_SPACE  = 3'd6,
    CL_OTHER  = 3'd7
  } char_class_e;

  // Automaton states, one-hot.
  typedef enum logic [8:0] {
    ST_START  = 9'b000000001,
    ST_IDENT  = 9'b000000010,
    ST_CONST  = 9'b000000100,
    ST_GT     = 9'b000001000,
    ST_ASSIGN = 9'b000010000,
    ST_ARITH  = 9'b000100000,
    ST_LT     = 9'b001000000,
    ST_EQEQ   = 9'b010000000,
    ST_ERROR  = 9'b100000000
  } state_e;

  // Token kinds as they appear on the result port.
  typedef enum logic [3:0] {
    KIND_FOR      = 4'd0,
    KIND_TO       = 4'd1,
    KIND_NEXT     = 4'd2,
    KIND_AND      = 4'd3,
    KIND_OR       = 4'd4,
    KIND_RELATION = 4'd5,
    KIND_ASSIGN   = 4'd6,
    KIND_ARITH    = 4'd7,
    KIND_IDENT    = 4'd8,
    KIND_CONST    = 4'd9,
    KIND_ERROR    = 4'd10
  } token_kind_e;

  // One step of the automaton: whether the open token finishes, whether the
  // current character then opens a new token, and the state otherwise taken.
  typedef struct packed {
    logic   finish;
    logic   restart;
    state_e nxt;
  } step_t;

  // First four bytes of a keyword, first byte in the low byte.
  localparam logic [31:0] KW_FOR  = 32'h0072_6F66;
  localparam logic [31:0] KW_TO   = 32'h0000_6F74;
  localparam logic [31:0] KW_NEXT = 32'h7478_656E;
  localparam logic [31:0] KW_AND  = 32'h0064_6E61;
  localparam logic [31:0] KW_OR   = 32'h0000_726F;

  localparam logic [7:0] MAX_ID_LEN_RESET = 8'd255;
  localparam logic [15:0] OUT_SAT         = 16'hFFFF;

  function automatic char_class_e char_class(logic [7:0] c);
    char_class_e cls;
    if (c inside {[8'd65:8'd90], [8'd97:8'd122]}) begin
      cls = CL_LETTER;
    end else if (c inside {[8'h30:8'h39]}) begin
      cls = CL_DIGIT;
    end else if (c == 8'h3E) begin
      cls = CL_GT;
    end else if (c == 8'h3C) begin
      cls = CL_LT;
    end else if (c == 8'h3D) begin
      cls = CL_EQ;
    end else if (c inside {8'h2B, 8'h2D, 8'h2A, 8'h2F}) begin
      cls = CL_ARITH;
    end else if (c inside {8'h20, 8'h09, 8'h0A, 8'h0D}) begin
      cls = CL_SPACE;
    end else begin
      cls = CL_OTHER;
    end
    return cls;
  endfunction

  // Transition of the automaton. In the start state the result gives the state
  // that a new token opens in; whitespace there is handled by the caller.
  function automatic step_t dfa_step(state_e st, char_class_e cls);
    step_t r;
    r.finish  = 1'b0;
    r.restart = 1'b0;
    r.nxt     = st;
    if (cls == CL_SPACE) begin
      r.finish = 1'b1;
    end else if (cls == CL_OTHER) begin
      r.nxt = ST_ERROR;
    end else begin
      case (st)
        ST_START: begin
          case (cls)
            CL_LETTER: r.nxt = ST_IDENT;
            CL_DIGIT:  r.nxt = ST_CONST;
            CL_GT:     r.nxt = ST_GT;
            CL_LT:     r.nxt = ST_LT;
            CL_EQ:     r.nxt = ST_ASSIGN;
            CL_ARITH:  r.nxt = ST_ARITH;
            default:   r.nxt = ST_ERROR;
          endcase
        end
        ST_IDENT: begin
          if (cls != CL_LETTER && cls != CL_DIGIT) begin
            r.finish  = 1'b1;
            r.restart = 1'b1;
          end
        end
        ST_CONST: begin
          if (cls == CL_LETTER) begin
            r.nxt = ST_ERROR;
          end else if (cls != CL_DIGIT) begin
            r.finish  = 1'b1;
            r.restart = 1'b1;
          end
        end
        ST_LT: begin
          if (cls == CL_GT) begin
            r.nxt = ST_GT;
          end else begin
            r.finish  = 1'b1;
            r.restart = 1'b1;
          end
        end
        ST_ASSIGN: begin
          if (cls == CL_EQ) begin
            r.nxt = ST_EQEQ;
          end else begin
            r.finish  = 1'b1;
            r.restart = 1'b1;
          end
        end
        ST_ERROR: begin
          r.nxt = ST_ERROR;
        end
        default: begin
          r.finish  = 1'b1;
          r.restart = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

endpackage

/* rtl/dfa_token_classifier_unit.sv */
// Token classifier top level: input register, lexing automaton, result register and
// the configuration port. Depends on dtc_pkg for classes, states, kinds and transitions.
//
// This block lexes a byte stream one character per transfer and reports each finished
// token as one result transfer carrying its kind, start offset and length. It sustains
// one character per clock cycle while the output is not stalled; the character that ends
// a token is held in the input register and the token is then written to the result
// register. Whitespace ends a token and is otherwise skipped; an operator or other
// character that cannot extend the open token finishes it and opens the next one, but an
// unclassified character, or a letter after a constant, turns it into an error token.
// Because a token is only reported once a later character ends it, the text should end
// in whitespace, otherwise its last token stays open. Offsets and lengths count in
// OFFSET_WIDTH-bit saturating counters and are clipped to 16 bits on output.
// The maximum identifier length register sits at byte address 0 and resets to 255;
// longer identifiers are reported as error tokens. It should only be written while no
// characters are in flight. Both channels move data when valid is high and stall low.
module dfa_token_classifier_unit #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // character input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  char_code_i,
  // token output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  token_kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [OFFSET_WIDTH-1:0] CNT_MAX = {OFFSET_WIDTH{1'b1}};

  // Input register.
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q, char_d;

  // Automaton state and counters.
  dtc_pkg::state_e         state_q, state_d;
  logic [OFFSET_WIDTH-1:0] byte_offset_q, byte_offset_d;
  logic [OFFSET_WIDTH-1:0] start_offset_q, start_offset_d;
  logic [OFFSET_WIDTH-1:0] run_length_q, run_length_d;
  logic [31:0]             kw_prefix_q, kw_prefix_d;

  // Configuration.
  logic [7:0] max_id_len_q, max_id_len_d;

  // Result register.
  logic        out_valid_q, out_valid_d;
  logic [3:0]  kind_q, kind_d;
  logic [15:0] start_q, start_d;
  logic [15:0] length_q, length_d;

  logic                  out_free;
  logic                  process;
  logic                  emit;
  dtc_pkg::char_class_e  cls;
  dtc_pkg::step_t        step;
  dtc_pkg::step_t        open_step;
  dtc_pkg::state_e       open_state;
  dtc_pkg::token_kind_e  kind;
  logic                  cfg_write;

  // The result register can take a new value when it is empty or being drained. The
  // character held in the input register is processed whenever that is so, whether or
  // not it finishes a token, which keeps the state update in step with the output.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign process    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  assign cls        = dtc_pkg::char_class(char_q);
  assign step       = dtc_pkg::dfa_step(state_q, cls);
  assign open_step  = dtc_pkg::dfa_step(dtc_pkg::ST_START, cls);
  assign open_state = open_step.nxt;

  // Kind of the token that is open now, as reported if this character finishes it.
  // Only an identifier can be a keyword; an over-long identifier is an error.
  always_comb begin
    case (state_q)
      dtc_pkg::ST_IDENT: begin
        if (run_length_q > OFFSET_WIDTH'(max_id_len_q)) begin
          kind = dtc_pkg::KIND_ERROR;
        end else if (run_length_q == OFFSET_WIDTH'(3) && kw_prefix_q == dtc_pkg::KW_FOR) begin
          kind = dtc_pkg::KIND_FOR;
        end else if (run_length_q == OFFSET_WIDTH'(2) && kw_prefix_q == dtc_pkg::KW_TO) begin
          kind = dtc_pkg::KIND_TO;
        end else if (run_length_q == OFFSET_WIDTH'(4) && kw_prefix_q == dtc_pkg::KW_NEXT) begin
          kind = dtc_pkg::KIND_NEXT;
        end else if (run_length_q == OFFSET_WIDTH'(3) && kw_prefix_q == dtc_pkg::KW_AND) begin
          kind = dtc_pkg::KIND_AND;
        end else if (run_length_q == OFFSET_WIDTH'(2) && kw_prefix_q == dtc_pkg::KW_OR) begin
          kind = dtc_pkg::KIND_OR;
        end else begin
          kind = dtc_pkg::KIND_IDENT;
        end
      end
      dtc_pkg::ST_CONST:  kind = dtc_pkg::KIND_CONST;
      dtc_pkg::ST_GT:     kind = dtc_pkg::KIND_RELATION;
      dtc_pkg::ST_LT:     kind = dtc_pkg::KIND_RELATION;
      dtc_pkg::ST_EQEQ:   kind = dtc_pkg::KIND_RELATION;
      dtc_pkg::ST_ASSIGN: kind = dtc_pkg::KIND_ASSIGN;
      dtc_pkg::ST_ARITH:  kind = dtc_pkg::KIND_ARITH;
      default:            kind = dtc_pkg::KIND_ERROR;
    endcase
  end

  // Automaton update for the character in the input register.
  always_comb begin
    state_d        = state_q;
    byte_offset_d  = byte_offset_q;
    start_offset_d = start_offset_q;
    run_length_d   = run_length_q;
    kw_prefix_d    = kw_prefix_q;
    emit           = 1'b0;
    if (process) begin
      if (byte_offset_q != CNT_MAX) begin
        byte_offset_d = byte_offset_q + OFFSET_WIDTH'(1);
      end
      if (state_q == dtc_pkg::ST_START) begin
        // Between tokens: whitespace is skipped, anything else opens a token.
        if (cls != dtc_pkg::CL_SPACE) begin
          start_offset_d = byte_offset_q;
          run_length_d   = OFFSET_WIDTH'(1);
          kw_prefix_d    = {24'b0, char_q};
          state_d        = open_state;
        end
      end else if (step.finish) begin
        emit    = 1'b1;
        state_d = dtc_pkg::ST_START;
        if (step.restart) begin
          // The character that ended the token is the first of the next one.
          start_offset_d = byte_offset_q;
          run_length_d   = OFFSET_WIDTH'(1);
          kw_prefix_d    = {24'b0, char_q};
          state_d        = open_state;
        end
      end else begin
        // The first four characters are kept for the keyword compare.
        if (run_length_q < OFFSET_WIDTH'(4)) begin
          kw_prefix_d = kw_prefix_q | ({24'b0, char_q} << {run_length_q[1:0], 3'b000});
        end
        if (run_length_q != CNT_MAX) begin
          run_length_d = run_length_q + OFFSET_WIDTH'(1);
        end
        state_d = step.nxt;
      end
    end
  end

  // Input register takes a new character whenever it is not held.
  always_comb begin
    in_valid_d = in_valid_q;
    char_d     = char_q;
    if (!in_stall_o) begin
      in_valid_d = in_valid_i;
      char_d     = char_code_i;
    end
  end

  // Result register; offsets and lengths wider than the port are clipped.
  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    start_d     = start_q;
    length_d    = length_q;
    if (out_free) begin
      out_valid_d = emit;
    end
    if (emit) begin
      kind_d   = 4'(kind);
      start_d  = (start_offset_q > OFFSET_WIDTH'(dtc_pkg::OUT_SAT)) ?
                 dtc_pkg::OUT_SAT : 16'(start_offset_q);
      length_d = (run_length_q > OFFSET_WIDTH'(dtc_pkg::OUT_SAT)) ?
                 dtc_pkg::OUT_SAT : 16'(run_length_q);
    end
  end

  // Configuration port: one register at byte address 0, no wait states.
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == 1'b0) ? {24'b0, max_id_len_q} : 32'b0;

  always_comb begin
    max_id_len_d = max_id_len_q;
    if (cfg_write && paddr[2] == 1'b0) begin
      max_id_len_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      state_q        <= dtc_pkg::ST_START;
      byte_offset_q  <= '0;
      start_offset_q <= '0;
      run_length_q   <= '0;
      kw_prefix_q    <= '0;
      max_id_len_q   <= dtc_pkg::MAX_ID_LEN_RESET;
    end else begin
      in_valid_q     <= in_valid_d;
      out_valid_q    <= out_valid_d;
      state_q        <= state_d;
      byte_offset_q  <= byte_offset_d;
      start_offset_q <= start_offset_d;
      run_length_q   <= run_length_d;
      kw_prefix_q    <= kw_prefix_d;
      max_id_len_q   <= max_id_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    kind_q   <= kind_d;
    start_q  <= start_d;
    length_q <= length_d;
  end

  assign out_valid_o    = out_valid_q;
  assign token_kind_o   = kind_q;
  assign token_start_o  = start_q;
  assign token_length_o = length_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for dfa_token_classifier_unit: a lexer model predicts every token.
// Depends on dtc_pkg for the class, state and token kind types, and on the RTL alone.
module tb_top;
  import dtc_pkg::*;

  // Settings of the run. The counters in the block are OFFSET_W bits wide and saturate.
  localparam int OFFSET_W = 16;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 200;
  localparam int REPORT_LIMIT = 10;
  localparam longint unsigned COUNT_MAX = (64'd1 << OFFSET_W) - 1;

  // Register map: the identifier limit is the only register; byte address 4 decodes to nothing.
  localparam logic [2:0] ADDR_ID_LIMIT = 3'd0;
  localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // First four bytes of each keyword with the first character in the low byte, which is
  // why the letters read backwards here.
  localparam logic [31:0] WORD_FOR  = {8'h00, "rof"};
  localparam logic [31:0] WORD_TO   = {16'h0000, "ot"};
  localparam logic [31:0] WORD_NEXT = "txen";
  localparam logic [31:0] WORD_AND  = {8'h00, "dna"};
  localparam logic [31:0] WORD_OR   = {16'h0000, "ro"};

  typedef struct packed {
    token_kind_e kind;
    logic [15:0] start;
    logic [15:0] length;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  char_code_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  token_kind_o;
  logic [15:0] token_start_o;
  logic [15:0] token_length_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  dfa_token_classifier_unit #(
    .OFFSET_WIDTH(OFFSET_W)
  ) dut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_kind_o   (token_kind_o),
    .token_start_o  (token_start_o),
    .token_length_o (token_length_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Lexer model: its own copy of the automaton state, the counters and the register.
  state_e            lex_state = ST_START;
  longint unsigned   lex_pos = 0;
  longint unsigned   tok_start = 0;
  longint unsigned   tok_len = 0;
  logic [31:0]       tok_prefix = 32'h0;
  logic [7:0]        id_limit = 8'd255;
  token_t            token_q[$];

  int                mismatches = 0;
  int unsigned       cycle_count = 0;
  int                send_idle_pct = 0;
  int                stall_pct = 0;
  int                text_bytes = 0;
  int                hold_requests = 0;
  int                hold_served = 0;
  int                hold_left = 0;

  string keyword_words [5] = '{"for", "to", "next", "and", "or"};
  string operator_texts [12] = '{"<", ">", "<>", "=", "==", "+", "-", "*", "/", "<=", ">>",
                                 "==="};

  function automatic char_class_e class_of(logic [7:0] c);
    char_class_e cls;
    case (c)
      8'h3E: cls = CL_GT;
      8'h3C: cls = CL_LT;
      8'h3D: cls = CL_EQ;
      8'h2B, 8'h2D, 8'h2A, 8'h2F: cls = CL_ARITH;
      8'h20, 8'h09, 8'h0A, 8'h0D: cls = CL_SPACE;
      default: begin
        if ((c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122)) begin
          cls = CL_LETTER;
        end else if (c >= 8'h30 && c <= 8'h39) begin
          cls = CL_DIGIT;
        end else begin
          cls = CL_OTHER;
        end
      end
    endcase
    return cls;
  endfunction

  function automatic longint unsigned sat_inc(longint unsigned v);
    return (v < COUNT_MAX) ? v + 1 : v;
  endfunction

  function automatic logic [15:0] clip16(longint unsigned v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // State in which a token opens, given its first character.
  function automatic state_e opening_state(char_class_e cls);
    state_e st;
    case (cls)
      CL_LETTER: st = ST_IDENT;
      CL_DIGIT:  st = ST_CONST;
      CL_GT:     st = ST_GT;
      CL_LT:     st = ST_LT;
      CL_EQ:     st = ST_ASSIGN;
      CL_ARITH:  st = ST_ARITH;
      default:   st = ST_ERROR;
    endcase
    return st;
  endfunction

  // Kind of the open token as it finishes. The length limit is checked before the keywords,
  // so an over-long keyword becomes an error.
  function automatic token_kind_e closing_kind();
    token_kind_e kind;
    case (lex_state)
      ST_IDENT: begin
        if (tok_len > id_limit) begin
          kind = KIND_ERROR;
        end else if (tok_len == 3 && tok_prefix == WORD_FOR) begin
          kind = KIND_FOR;
        end else if (tok_len == 2 && tok_prefix == WORD_TO) begin
          kind = KIND_TO;
        end else if (tok_len == 4 && tok_prefix == WORD_NEXT) begin
          kind = KIND_NEXT;
        end else if (tok_len == 3 && tok_prefix == WORD_AND) begin
          kind = KIND_AND;
        end else if (tok_len == 2 && tok_prefix == WORD_OR) begin
          kind = KIND_OR;
        end else begin
          kind = KIND_IDENT;
        end
      end
      ST_CONST:                  kind = KIND_CONST;
      ST_GT, ST_LT, ST_EQEQ:     kind = KIND_RELATION;
      ST_ASSIGN:                 kind = KIND_ASSIGN;
      ST_ARITH:                  kind = KIND_ARITH;
      default:                   kind = KIND_ERROR;
    endcase
    return kind;
  endfunction

  task automatic open_token(input logic [7:0] c, input char_class_e cls,
                            input longint unsigned at);
    tok_start  = at;
    tok_len    = 1;
    tok_prefix = {24'h0, c};
    lex_state  = opening_state(cls);
  endtask

  // Advances the lexer model by one accepted character and queues the token it finishes.
  task automatic lex_char(input logic [7:0] c);
    char_class_e     cls;
    longint unsigned here;
    logic            ends;
    logic            reopens;
    state_e          nxt;
    token_t          tok;
    cls = class_of(c);
    here = lex_pos;
    lex_pos = sat_inc(lex_pos);
    if (lex_state == ST_START) begin
      // Whitespace between tokens moves the offset and nothing else.
      if (cls != CL_SPACE) open_token(c, cls, here);
    end else begin
      ends = 1'b0;
      reopens = 1'b0;
      nxt = lex_state;
      if (cls == CL_SPACE) begin
        ends = 1'b1;
      end else if (cls == CL_OTHER) begin
        nxt = ST_ERROR;
      end else begin
        case (lex_state)
          ST_IDENT: reopens = !(cls == CL_LETTER || cls == CL_DIGIT);
          ST_CONST: begin
            if (cls == CL_LETTER) nxt = ST_ERROR;
            else reopens = (cls != CL_DIGIT);
          end
          ST_LT: begin
            if (cls == CL_GT) nxt = ST_GT;
            else reopens = 1'b1;
          end
          ST_ASSIGN: begin
            if (cls == CL_EQ) nxt = ST_EQEQ;
            else reopens = 1'b1;
          end
          ST_ERROR: ;
          default: reopens = 1'b1;
        endcase
        ends = reopens;
      end
      if (ends) begin
        tok.kind   = closing_kind();
        tok.start  = clip16(tok_start);
        tok.length = clip16(tok_len);
        token_q = {token_q, tok};
        lex_state = ST_START;
        if (reopens) open_token(c, cls, here);
      end else begin
        if (tok_len < 4) tok_prefix = tok_prefix | (32'(c) << (8 * tok_len));
        tok_len = sat_inc(tok_len);
        lex_state = nxt;
      end
    end
  endtask

  function automatic void log_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Token checker: every result transfer is compared with the oldest predicted token.
  always @(posedge clk) begin : check_tokens
    token_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (token_q.size() == 0) begin
        log_mismatch($sformatf("unexpected token: kind %0d start %0d length %0d",
                               token_kind_o, token_start_o, token_length_o));
      end else begin
        want = token_q.pop_front();
        if (token_kind_o !== want.kind || token_start_o !== want.start ||
            token_length_o !== want.length) begin
          log_mismatch($sformatf(
            "token mismatch: expected kind %0d start %0d length %0d, got %0d %0d %0d",
            want.kind, want.start, want.length,
            token_kind_o, token_start_o, token_length_o));
        end
      end
    end
  end

  // Receiver: random stalls at the current rate, or a long hold-off when one is requested.
  // The hold-off is counted here so that the sender keeps offering characters meanwhile.
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offers one character and returns at the falling edge after its transfer. An idle gap
  // only lowers valid; once raised it stays high, with the same byte, until accepted.
  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk);
    end
    in_valid_i <= 1'b1;
    char_code_i <= c;
    do @(posedge clk); while (in_stall_o);
    lex_char(c);
    if (class_of(c) != CL_SPACE) text_bytes++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? 8'd65 : 8'd97) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] c;
    case ($urandom_range(3))
      0: c = CH_SPACE;
      1: c = CH_TAB;
      2: c = CH_LF;
      default: c = CH_CR;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rand_other();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (class_of(c) != CL_OTHER);
    return c;
  endfunction

  task automatic send_ident(input int len);
    send_char(rand_letter());
    repeat (len - 1) send_char($urandom_range(1) ? rand_letter() : rand_digit());
  endtask

  // Waits until every predicted token has arrived, then lets the pipeline empty, so that
  // the register can be written with no character in flight.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ID_LIMIT) id_limit = value[7:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] expected);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== expected) begin
      log_mismatch($sformatf("register read at %0d: expected %0d, got %0d",
                             addr, expected, got));
    end
  endtask

  // Writes the identifier limit with random upper bits, which the register drops.
  task automatic set_id_limit(input logic [7:0] limit);
    logic [31:0] noise;
    noise = $urandom();
    wait_idle();
    apb_write(ADDR_ID_LIMIT, {noise[31:8], limit});
    apb_read_check(ADDR_ID_LIMIT, {24'h0, limit});
  endtask

  // One random token, mostly well formed, followed by whitespace most of the time. Without
  // whitespace the next token starts right after, which exercises the restart rules.
  task automatic send_random_token();
    int    pick;
    int    flip;
    string w;
    pick = $urandom_range(99);
    if (pick < 20) begin
      // Keywords, sometimes with one letter in the wrong case, extended, cut short or spoilt.
      w = keyword_words[$urandom_range(4)];
      flip = ($urandom_range(7) == 0) ? $urandom_range(w.len() - 1) : -1;
      for (int i = 0; i < w.len(); i++) begin
        if (i == flip) send_char(w[i] ^ 8'h20);
        else if (!(i == w.len() - 1 && $urandom_range(9) == 0)) send_char(w[i]);
      end
      case ($urandom_range(9))
        0: send_char($urandom_range(1) ? rand_letter() : rand_digit());
        1: send_char(rand_other());
        default: ;
      endcase
    end else if (pick < 40) begin
      send_ident(($urandom_range(99) == 0) ? $urandom_range(200, 300) : $urandom_range(1, 12));
    end else if (pick < 55) begin
      repeat ($urandom_range(1, 10)) send_char(rand_digit());
      // A letter straight after the digits turns the constant into an error token.
      if ($urandom_range(6) == 0) send_ident($urandom_range(1, 3));
    end else if (pick < 80) begin
      send_text(operator_texts[$urandom_range(11)]);
    end else if (pick < 90) begin
      send_char(rand_other());
      repeat ($urandom_range(4)) send_char(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)));
    end
    if ($urandom_range(9) < 7) repeat ($urandom_range(1, 2)) send_char(rand_space());
  endtask

  // Reset value of the register, and a write to an unmapped address that must not reach it.
  task automatic test_register_access();
    apb_read_check(ADDR_ID_LIMIT, 32'd255);
    wait_idle();
    apb_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    apb_read_check(ADDR_ID_LIMIT, 32'd255);
  endtask

  // Every token kind but the constant in one short text: keywords split by arithmetic signs,
  // the relations, assignment, an identifier, a constant turned error by a letter after its
  // digit, and the extreme bytes absorbed by the error token until the tab ends it.
  task automatic test_directed_text();
    send_idle_pct = 0;
    stall_pct = 0;
    send_text("for+to-next*and/or<>=x==>9a");
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_TAB);
  endtask

  // Identifier length limit around its edges, including zero, where every identifier is an
  // error, and the full limit with identifiers one below, at and above it.
  task automatic test_identifier_limit();
    set_id_limit(8'd0);
    send_text("to x9 7 ");
    set_id_limit(8'd1);
    send_text("a ab or ");
    set_id_limit(8'd2);
    send_text("or for to ");
    set_id_limit(8'd4);
    send_text("next nexta abcd abcde ");
    set_id_limit(8'd255);
    send_ident(254);
    send_char(CH_SPACE);
    send_ident(255);
    send_char(CH_SPACE);
    send_ident(256);
    send_char(CH_LF);
  endtask

  task automatic test_random_text(input int idle, input int stall, input logic [7:0] limit,
                                  input int n);
    set_id_limit(limit);
    send_idle_pct = idle;
    stall_pct = stall;
    text_bytes = 0;
    while (text_bytes < n) send_random_token();
    // Close whatever token is still open before the next register write.
    send_char(CH_SPACE);
  endtask

  // The receiver holds off for a long stretch while characters keep coming, so the block
  // fills up and has to stall its input.
  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests <= hold_requests + 1;
    repeat (40) begin
      send_char(rand_letter());
      send_char(CH_SPACE);
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    test_register_access();
    test_directed_text();
    test_identifier_limit();
    test_random_text(0, 0, 8'd255, 160);
    test_random_text(72, 0, 8'd1, 160);
    test_random_text(0, 72, 8'd0, 160);
    test_random_text(21, 21, 8'($urandom_range(2, 254)), 160);
    test_backpressure();
    wait_idle();

    if (mismatches == 0 && token_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
